// ===== rtl/stack_machine_executor_assert.svh =====
// assertion macros shared by the stack machine executor rtl
// expects clk and arst_n in the scope of each use
`ifndef STACK_MACHINE_EXECUTOR_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_ASSERT_SVH

// same-cycle implication
`define SME_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SME_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sme_pkg.sv =====
// shared types and codes for the stack machine executor
// no dependencies
package sme_pkg;

	typedef enum logic [3:0] {
		OP_PUSH  = 4'd0,
		OP_POP   = 4'd1,
		OP_ADD   = 4'd2,
		OP_SUB   = 4'd3,
		OP_MUL   = 4'd4,
		OP_DIV   = 4'd5,
		OP_IFEQ  = 4'd6,
		OP_JUMP  = 4'd7,
		OP_PRINT = 4'd8,
		OP_DUP   = 4'd9
	} op_t;

	typedef enum logic [2:0] {
		ERR_OK      = 3'd0,
		ERR_INVALID = 3'd1,
		ERR_UNDER   = 3'd2,
		ERR_OVER    = 3'd3,
		ERR_DIVZERO = 3'd4
	} err_t;

	localparam int unsigned WORD_W = 32;

	// request to the divider
	typedef struct packed {
		logic start;
		logic is_signed;
	} div_ctrl_t;

endpackage

// ===== rtl/sme_cmd_if.sv =====
// instruction channel: decoded opcode and operand
// no dependencies
interface sme_cmd_if;
	logic               valid;
	logic               ready;
	logic        [3:0]  func;
	logic signed [31:0] operand;

	modport source (output valid, func, operand, input ready);
	modport sink   (input valid, func, operand, output ready);
endinterface

// ===== rtl/sme_rsp_if.sv =====
// result channel: top of stack, line counter and status per instruction
// no dependencies
interface sme_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] top_value;
	logic               print_valid;
	logic        [7:0]  next_line;
	logic        [2:0]  error_code;
	logic        [4:0]  stack_count;

	modport source (output valid, top_value, print_valid, next_line, error_code, stack_count,
		input ready);
	modport sink   (input valid, top_value, print_valid, next_line, error_code, stack_count,
		output ready);
endinterface

// ===== rtl/stack_machine_executor.sv =====
// stack machine executor: one decoded instruction per word on a ram-held data stack
// order: exec, then mod1 and mod2 for a taken jump or ifeq (reciprocal target reduction)
// or the bit-serial divider wait for div, then done, which loads the output register
// throughput: one instruction at a time; a held result stalls the next
// reset: stack pointer, line counter and handshakes clear; stack contents undefined until pushed
// depends on sme_pkg, sme_cmd_if, sme_rsp_if, sme_stack_ram, sme_div
`include "stack_machine_executor_assert.svh"

module stack_machine_executor import sme_pkg::*; #(
	parameter int unsigned STACK_DEPTH = 16,
	parameter int unsigned LINE_COUNT  = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	sme_cmd_if.sink   cmd,
	sme_rsp_if.source rsp
);

	localparam int unsigned AW  = $clog2(STACK_DEPTH);
	localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned LW  = $clog2(LINE_COUNT);

	// reciprocal of the line count, exact quotient for any 32-bit target
	localparam int unsigned MOD_S = 32 + LW;
	localparam logic [32:0] MOD_M = 33'(((64'd1 << MOD_S) / 64'(LINE_COUNT)) + 64'd1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_MOD1 = 6'b000100,
		S_MOD2 = 6'b001000,
		S_DIV  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;

	logic [SPW-1:0] sp_q;
	logic [LW-1:0]  line_q;
	logic           rsp_valid_q;

	// instruction held across the step
	logic [3:0]  func_q;
	logic [31:0] operand_q;

	// step results, loaded in exec, in mod2 and in the divider wait
	err_t           err_q;
	logic [SPW-1:0] sp_nx_q;
	logic [LW-1:0]  line_nx_q;
	logic [31:0]    top_q;
	logic           print_q;
	logic           we_q;
	logic [AW-1:0]  waddr_q;
	logic [31:0]    wdata_q;

	// output register
	logic [31:0] rsp_top_q;
	logic        rsp_print_q;
	logic [7:0]  rsp_line_q;
	err_t        rsp_err_q;
	logic [4:0]  rsp_count_q;

	// target reduction pipeline
	logic [48:0]   mod_lo_s1;
	logic [48:0]   mod_hi_s1;
	logic [31:0]   mod_quo_s2;
	logic [64:0]   mod_sum;
	logic [LW-1:0] mod_qn;
	logic [LW-1:0] mod_rem;

	logic          accept;
	logic          advance;
	logic          mem_we;
	logic [AW-1:0] raddr_a;
	logic [AW-1:0] raddr_b;
	logic [31:0]   rd_a;
	logic [31:0]   rd_b;

	div_ctrl_t   div_ctrl;
	logic [31:0] div_dividend;
	logic [31:0] div_divisor;
	logic        div_done;
	logic [31:0] div_quot;

	// exec decode
	err_t           err;
	logic [SPW-1:0] sp_nx;
	logic [LW-1:0]  line_nx;
	logic [LW-1:0]  line_inc;
	logic [31:0]    top_nx;
	logic [31:0]    cur_top;
	logic           printed;
	logic           we_nx;
	logic [AW-1:0]  waddr_nx;
	logic [31:0]    wdata_nx;
	logic           need_div;
	logic           need_mod;
	logic           full;

	assign accept  = cmd.valid && cmd.ready;
	assign advance = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);
	assign mem_we  = advance && we_q;

	assign cmd.ready = (state_q == S_IDLE);

	// top and next; address zero when the entry does not exist
	assign raddr_a = (sp_q >= SPW'(1)) ? AW'(sp_q - SPW'(1)) : '0;
	assign raddr_b = (sp_q >= SPW'(2)) ? AW'(sp_q - SPW'(2)) : '0;

	sme_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (waddr_q),
		.wdata   (wdata_q),
		.re      (accept),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	sme_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign full     = (sp_q == SPW'(STACK_DEPTH));
	assign cur_top  = (sp_q == '0) ? 32'd0 : rd_a;
	assign line_inc = (line_q == LW'(LINE_COUNT - 1)) ? '0 : line_q + LW'(1);

	always_comb begin
		err      = ERR_OK;
		sp_nx    = sp_q;
		line_nx  = line_inc;
		top_nx   = cur_top;
		printed  = 1'b0;
		we_nx    = 1'b0;
		waddr_nx = AW'(sp_q);
		wdata_nx = operand_q;
		need_div = 1'b0;
		need_mod = 1'b0;
		unique case (func_q)
			OP_PUSH: begin
				if (full) begin
					err = ERR_OVER;
				end else begin
					sp_nx  = sp_q + SPW'(1);
					we_nx  = 1'b1;
					top_nx = operand_q;
				end
			end
			OP_POP: begin
				if (sp_q == '0) begin
					err = ERR_UNDER;
				end else begin
					sp_nx  = sp_q - SPW'(1);
					top_nx = (sp_q == SPW'(1)) ? 32'd0 : rd_b;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (sp_q < SPW'(2)) begin
					err = ERR_UNDER;
				end else if (func_q == OP_DIV && rd_b == 32'd0) begin
					err = ERR_DIVZERO;
				end else begin
					sp_nx    = sp_q - SPW'(1);
					we_nx    = 1'b1;
					waddr_nx = AW'(sp_q - SPW'(2));
					case (func_q)
						OP_ADD:  top_nx = rd_a + rd_b;
						OP_SUB:  top_nx = rd_a - rd_b;
						OP_MUL:  top_nx = rd_a * rd_b;
						default: begin
							top_nx   = 32'd0;
							need_div = 1'b1;
						end
					endcase
					wdata_nx = top_nx;
				end
			end
			OP_IFEQ: begin
				if (sp_q == '0) begin
					err = ERR_UNDER;
				end else if (rd_a == 32'd0) begin
					need_mod = 1'b1;
				end
			end
			OP_JUMP: begin
				need_mod = 1'b1;
			end
			OP_PRINT: begin
				if (sp_q == '0) begin
					err = ERR_UNDER;
				end else begin
					printed = 1'b1;
				end
			end
			OP_DUP: begin
				if (sp_q == '0) begin
					err = ERR_UNDER;
				end else if (full) begin
					err = ERR_OVER;
				end else begin
					sp_nx    = sp_q + SPW'(1);
					we_nx    = 1'b1;
					wdata_nx = rd_a;
				end
			end
			default: begin
				err = ERR_INVALID;
			end
		endcase
		// an error leaves all state as it was
		if (err != ERR_OK) begin
			sp_nx    = sp_q;
			line_nx  = line_q;
			top_nx   = cur_top;
			printed  = 1'b0;
			we_nx    = 1'b0;
			need_div = 1'b0;
			need_mod = 1'b0;
		end
	end

	// divider runs signed on top over next for div
	always_comb begin
		div_ctrl.start     = (state_q == S_EXEC) && need_div;
		div_ctrl.is_signed = need_div;
		div_dividend       = rd_a;
		div_divisor        = rd_b;
	end

	// target mod line count: quotient by reciprocal, remainder from the low bits
	assign mod_sum = {mod_hi_s1, 16'd0} + 65'(mod_lo_s1);
	assign mod_qn  = LW'(mod_quo_s2) * LW'(LINE_COUNT);
	assign mod_rem = LW'(operand_q) - mod_qn;

	always_ff @(posedge clk) begin
		mod_lo_s1  <= 49'(operand_q[15:0]) * 49'(MOD_M);
		mod_hi_s1  <= 49'(operand_q[31:16]) * 49'(MOD_M);
		mod_quo_s2 <= 32'(mod_sum >> MOD_S);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			line_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= need_mod ? S_MOD1 : (need_div ? S_DIV : S_DONE);
				end
				S_MOD1: begin
					state_q <= S_MOD2;
				end
				S_MOD2: begin
					state_q <= S_DONE;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (advance) begin
						sp_q        <= sp_nx_q;
						line_q      <= line_nx_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= cmd.func;
			operand_q <= cmd.operand;
		end
		if (state_q == S_EXEC) begin
			err_q     <= err;
			sp_nx_q   <= sp_nx;
			line_nx_q <= line_nx;
			top_q     <= top_nx;
			print_q   <= printed;
			we_q      <= we_nx;
			waddr_q   <= waddr_nx;
			wdata_q   <= wdata_nx;
		end
		if (state_q == S_MOD2) begin
			line_nx_q <= mod_rem;
		end
		if (state_q == S_DIV && div_done) begin
			top_q   <= div_quot;
			wdata_q <= div_quot;
		end
		if (advance) begin
			rsp_top_q   <= top_q;
			rsp_print_q <= print_q;
			rsp_line_q  <= 8'(line_nx_q);
			rsp_err_q   <= err_q;
			rsp_count_q <= 5'(sp_nx_q);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.top_value   = $signed(rsp_top_q);
	assign rsp.print_valid = rsp_print_q;
	assign rsp.next_line   = rsp_line_q;
	assign rsp.error_code  = rsp_err_q;
	assign rsp.stack_count = rsp_count_q;

	`SME_ASSERT_NOW(a_sp_bound, 1'b1, 32'(sp_q) <= STACK_DEPTH, "stack pointer past depth")
	`SME_ASSERT_NOW(a_line_bound, 1'b1, 32'(line_q) < LINE_COUNT, "line counter past line count")
	`SME_ASSERT_NEXT(a_err_hold, advance && err_q != ERR_OK, $stable({sp_q, line_q}), "moved on error")
	`SME_ASSERT_NOW(a_no_rw_overlap, mem_we, !accept, "stack write overlaps a read")
	`SME_ASSERT_NOW(a_print_ok, rsp.valid && rsp.print_valid, rsp.error_code == ERR_OK, "print flagged with error")

endmodule

// ===== rtl/sme_stack_ram.sv =====
// data stack storage: one write port, two registered read ports
// depends on nothing but its parameters
module sme_stack_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [31:0]   rdata_a,
	output logic [31:0]   rdata_b
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== rtl/sme_div.sv =====
// restoring divider, one quotient bit per cycle, signed or unsigned
// depends on sme_pkg
module sme_div import sme_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_ctrl_t   ctrl,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quot
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] num_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic        neg_q;

	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q, num_q[31]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			// magnitudes; the most negative word keeps its pattern, read as 2^31
			num_q <= (ctrl.is_signed && dividend[31]) ? (~dividend + 32'd1) : dividend;
			den_q <= (ctrl.is_signed && divisor[31])  ? (~divisor + 32'd1)  : divisor;
			neg_q <= ctrl.is_signed && (dividend[31] ^ divisor[31]);
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				num_q <= {num_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				num_q <= {num_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = neg_q ? (~num_q + 32'd1) : num_q;

endmodule

// ===== tb/sme_exec_checker.sv =====
// checker for the stack machine executor: watches both channels, predicts each result
// word from the accepted instruction words and compares them field by field
// depends on sme_pkg, sme_cmd_if, sme_rsp_if
module sme_exec_checker import sme_pkg::*; #(
	parameter int unsigned STACK_DEPTH = 16,
	parameter int unsigned LINE_COUNT  = 256
) (
	input  logic  clk,
	input  logic  arst_n,
	sme_cmd_if    cmd,
	sme_rsp_if    rsp,
	output int    fail_count,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] top;
		logic        printed;
		logic [7:0]  line;
		logic [2:0]  err;
		logic [4:0]  count;
	} exec_result_t;

	logic [31:0]  stack_words [STACK_DEPTH];
	int unsigned  stack_depth;
	int unsigned  line_ctr;
	exec_result_t expected_q [$];
	int           mismatches = 0;

	// runs one instruction word on the shadow stack, returns the result word it should give
	function automatic exec_result_t execute_word(logic [3:0] func, logic [31:0] operand);
		exec_result_t res;
		err_t         err;
		int unsigned  sp;
		int unsigned  next;
		logic [31:0]  a;
		logic [31:0]  b;
		logic [31:0]  v;
		longint       qa;
		longint       qb;
		err = ERR_OK;
		res.printed = 1'b0;
		sp = stack_depth;
		next = (line_ctr + 1) % LINE_COUNT;
		v = '0;
		if (func > OP_DUP) begin
			err = ERR_INVALID;
		end else begin
			case (func)
				OP_PUSH: begin
					if (sp >= STACK_DEPTH) err = ERR_OVER;
					else begin
						stack_words[sp] = operand;
						sp++;
					end
				end
				OP_JUMP: next = operand % LINE_COUNT;
				OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
					if (sp < 2) err = ERR_UNDER;
					else begin
						// top is the left operand
						a = stack_words[sp - 1];
						b = stack_words[sp - 2];
						case (func)
							OP_ADD: v = a + b;
							OP_SUB: v = a - b;
							OP_MUL: v = a * b;
							default: begin
								if (b == '0) err = ERR_DIVZERO;
								else begin
									// 64-bit quotient so the most negative over -1 wraps
									qa = $signed(a);
									qb = $signed(b);
									v = 32'(qa / qb);
								end
							end
						endcase
						if (err == ERR_OK) begin
							sp--;
							stack_words[sp - 1] = v;
						end
					end
				end
				default: begin
					if (sp == 0) err = ERR_UNDER;
					else begin
						case (func)
							OP_POP: sp--;
							OP_IFEQ: if (stack_words[sp - 1] == '0) next = operand % LINE_COUNT;
							OP_PRINT: res.printed = 1'b1;
							default: begin
								if (sp >= STACK_DEPTH) err = ERR_OVER;
								else begin
									stack_words[sp] = stack_words[sp - 1];
									sp++;
								end
							end
						endcase
					end
				end
			endcase
		end
		if (err == ERR_OK) begin
			stack_depth = sp;
			line_ctr = next;
		end
		res.top = (stack_depth != 0) ? stack_words[stack_depth - 1] : '0;
		res.line = line_ctr[7:0];
		res.err = err;
		res.count = stack_depth[4:0];
		return res;
	endfunction

	task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		exec_result_t want;
		if (!arst_n) begin
			stack_depth = 0;
			line_ctr = 0;
			expected_q.delete();
			pending <= 0;
			fail_count <= mismatches;
		end else begin
			if (cmd.valid && cmd.ready)
				expected_q.push_back(execute_word(cmd.func, cmd.operand));
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result word with nothing expected, top %0h line %0h err %0h",
						$time, rsp.top_value, rsp.next_line, rsp.error_code);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					check_field("top_value", want.top, rsp.top_value);
					check_field("print_valid", 32'(want.printed), 32'(rsp.print_valid));
					check_field("next_line", 32'(want.line), 32'(rsp.next_line));
					check_field("error_code", 32'(want.err), 32'(rsp.error_code));
					check_field("stack_count", 32'(want.count), 32'(rsp.stack_count));
				end
			end
			pending <= expected_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// top of the stack machine executor testbench: clock, reset, instruction and result stimulus
// and the verdict; prediction and comparison live in sme_exec_checker
// depends on sme_pkg, sme_cmd_if, sme_rsp_if, sme_exec_checker, stack_machine_executor
module tb_top import sme_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_WORDS = 650;
	localparam int unsigned DRAIN_AT     = 300;
	localparam int unsigned HOLD_AT      = 120;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned TAIL_CYCLES  = 60;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam logic [3:0]  FUNC_INVALID_LO = 4'd10;
	localparam logic [3:0]  FUNC_INVALID_HI = 4'd15;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int          fail_count;
	int          pending;
	int unsigned sender_idle_pct = 28;
	int unsigned receiver_idle_pct = 48;
	int unsigned cycle_count = 0;

	sme_cmd_if cmd_ch();
	sme_rsp_if rsp_ch();

	stack_machine_executor u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	sme_exec_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** stack_machine_executor: FAILED **");
			$finish;
		end
	end

	// result side: random back-pressure plus one long hold-off so the block backs up
	initial begin
		int unsigned results_seen;
		int unsigned hold_left;
		bit          hold_done;
		results_seen = 0;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (rsp_ch.valid && rsp_ch.ready) results_seen++;
				if (hold_left != 0) begin
					hold_left--;
					rsp_ch.ready <= 1'b0;
				end else if (results_seen >= HOLD_AT && !hold_done) begin
					hold_done = 1'b1;
					hold_left = HOLD_CYCLES;
					rsp_ch.ready <= 1'b0;
				end else begin
					rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
				end
			end
		end
	end

	task automatic send_word(logic [3:0] func, logic [31:0] operand);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= func;
		cmd_ch.operand <= operand;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	// pending is registered behind the accept edge, hence the first wait
	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// grow runs favour push and dup so the stack fills, the others drain it
	function automatic logic [3:0] pick_func(bit grow);
		int unsigned r;
		r = $urandom_range(99);
		if (r < (grow ? 40 : 16)) return OP_PUSH;
		if (r < (grow ? 50 : 22)) return OP_DUP;
		if (r < (grow ? 55 : 37)) return OP_POP;
		if (r < (grow ? 75 : 73)) begin
			case ($urandom_range(3))
				0: return OP_ADD;
				1: return OP_SUB;
				2: return OP_MUL;
				default: return OP_DIV;
			endcase
		end
		if (r < 81) return OP_IFEQ;
		if (r < 85) return OP_JUMP;
		if (r < 94) return OP_PRINT;
		return 4'($urandom_range(FUNC_INVALID_LO, FUNC_INVALID_HI));
	endfunction

	// small values and zero keep divides and taken branches frequent
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3: return 32'hFFFF_FFFF;
			4, 5, 6: return 32'($urandom_range(40)) - 32'd20;
			7: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int unsigned run_left;
		bit          grow;
		run_left = 0;
		grow = 1'b1;
		cmd_ch.valid <= 1'b0;
		cmd_ch.func <= OP_PUSH;
		cmd_ch.operand <= '0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// empty stack: pop, add, print, ifeq and dup underflow, unknown opcodes rejected
		send_word(OP_POP, 32'h0);
		send_word(OP_ADD, 32'h0);
		send_word(OP_PRINT, 32'h0);
		send_word(OP_IFEQ, 32'h5);
		send_word(OP_DUP, 32'h0);
		send_word(FUNC_INVALID_HI, 32'hFFFF_FFFF);
		send_word(FUNC_INVALID_LO, 32'h0);
		send_word(OP_PUSH, 32'hFFFF_FFFF);
		send_word(OP_ADD, 32'h0);
		// most negative over minus one wraps
		send_word(OP_PUSH, 32'h8000_0000);
		send_word(OP_DIV, 32'h0);
		send_word(OP_PUSH, 32'h0);
		send_word(OP_IFEQ, 32'hFFFF_FF03);
		send_word(OP_DIV, 32'h0);
		send_word(OP_PUSH, 32'h7);
		send_word(OP_DIV, 32'h0);
		send_word(OP_PUSH, 32'h7FFF_FFFF);
		send_word(OP_DUP, 32'h0);
		send_word(OP_ADD, 32'h0);
		send_word(OP_MUL, 32'h0);
		send_word(OP_SUB, 32'h0);
		send_word(OP_PRINT, 32'h0);
		send_word(OP_IFEQ, 32'h9);
		send_word(OP_JUMP, 32'h1234_5678);
		send_word(OP_PUSH, 32'h2);
		send_word(OP_PUSH, 32'hFFFF_FFF9);
		send_word(OP_DIV, 32'h0);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 3) begin
				sender_idle_pct = 48;
				receiver_idle_pct = 28;
			end
			if (i == 2 * RANDOM_WORDS / 3) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			if (i == DRAIN_AT) drain_results();
			if (run_left == 0) begin
				grow = $urandom_range(1);
				run_left = $urandom_range(15, 40);
			end
			run_left--;
			send_word(pick_func(grow), pick_operand());
		end
		cmd_ch.valid <= 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("** stack_machine_executor: PASSED **");
		end else begin
			$display("** stack_machine_executor: FAILED **");
		end
		$finish;
	end

endmodule
